// ===== hdl/pta_pkg.sv =====
// shared types, constants and arithmetic helpers of the plucker transform block
`default_nettype none
package pta_pkg;

  localparam int unsigned ELEM_WIDTH    = 16;
  localparam int unsigned ROT_FRAC_BITS = 14;
  localparam int unsigned VEC_FRAC_BITS = 8;
  localparam int unsigned FIELD_W       = 48;
  localparam int unsigned OP_W          = 2;

  localparam int unsigned PROD_W = 2 * ELEM_WIDTH;
  localparam int unsigned C_W    = 2 * ELEM_WIDTH + 2 - VEC_FRAC_BITS;
  localparam int unsigned T_W    = ((C_W > ELEM_WIDTH) ? C_W : ELEM_WIDTH) + 1;
  localparam int unsigned QT_W   = ELEM_WIDTH + T_W;
  localparam int unsigned ACC_W  = QT_W + 3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_MOTION    = 2'd0,
    OP_FORCE     = 2'd1,
    OP_TR_FORCE  = 2'd2,
    OP_TR_MOTION = 2'd3
  } op_e;

  typedef logic signed [ELEM_WIDTH-1:0] lane_t;
  typedef logic [2:0][ELEM_WIDTH-1:0]   vec_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [T_W-1:0]        diff_t;
  typedef logic signed [QT_W-1:0]       qprod_t;
  typedef logic signed [ACC_W-1:0]      acc_t;

  typedef struct packed {
    logic           tr;
    logic           swap;
    logic [2:0][2:0][ELEM_WIDTH-1:0] q;
    vec_t           p;
    vec_t           a;
    vec_t           b;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [ELEM_WIDTH-1:0] v;
    logic                  f;
  } sat_t;

  function automatic int nxt(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

  function automatic int prv(input int i);
    return (i == 0) ? 2 : i - 1;
  endfunction

  function automatic acc_t rnd(input acc_t x, input int unsigned s);
    acc_t half;
    if (s == 0) begin
      return x;
    end
    half = acc_t'(1) <<< (s - 1);
    return (x + half) >>> s;
  endfunction

  function automatic sat_t sat_lane(input acc_t x);
    sat_t r;
    logic [ACC_W-ELEM_WIDTH:0] hi;
    hi = x[ACC_W-1:ELEM_WIDTH-1];
    if (hi == '0 || hi == '1) begin
      r.v = x[ELEM_WIDTH-1:0];
      r.f = 1'b0;
    end else if (x[ACC_W-1]) begin
      r.v = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
      r.f = 1'b1;
    end else begin
      r.v = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
      r.f = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pta_in_if.sv =====
// input channel of the plucker transform block
`default_nettype none
interface pta_in_if;
  logic                         valid;
  logic                         ready;
  logic [pta_pkg::OP_W-1:0]     op;
  logic [pta_pkg::FIELD_W-1:0]  rot_row0;
  logic [pta_pkg::FIELD_W-1:0]  rot_row1;
  logic [pta_pkg::FIELD_W-1:0]  rot_row2;
  logic [pta_pkg::FIELD_W-1:0]  offset;
  logic [pta_pkg::FIELD_W-1:0]  vec_lin;
  logic [pta_pkg::FIELD_W-1:0]  vec_ang;

  modport source (output valid, op, rot_row0, rot_row1, rot_row2, offset, vec_lin, vec_ang,
                  input ready);
  modport sink (input valid, op, rot_row0, rot_row1, rot_row2, offset, vec_lin, vec_ang,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/pta_out_if.sv =====
// output channel of the plucker transform block
`default_nettype none
interface pta_out_if;
  logic                         valid;
  logic                         ready;
  logic [pta_pkg::FIELD_W-1:0]  out_lin;
  logic [pta_pkg::FIELD_W-1:0]  out_ang;
  logic                         saturated;

  modport source (output valid, out_lin, out_ang, saturated, input ready);
  modport sink (input valid, out_lin, out_ang, saturated, output ready);
endinterface
`default_nettype wire

// ===== hdl/pta_front.sv =====
// front end: accepts input beats, decodes the op and lays out the matrix
`default_nettype none
module pta_front (
  pta_in_if.sink            in_i,
  input  pta_pkg::q_stat_t  stat_i,
  output logic              push_o,
  output pta_pkg::job_t     job_o
);

  localparam int unsigned E = pta_pkg::ELEM_WIDTH;

  logic [2:0][2:0][E-1:0] rot;

  assign in_i.ready = !stat_i.full;
  assign push_o     = in_i.valid && !stat_i.full;

  assign rot[0] = in_i.rot_row0[3*E-1:0];
  assign rot[1] = in_i.rot_row1[3*E-1:0];
  assign rot[2] = in_i.rot_row2[3*E-1:0];

  always_comb begin
    job_o = '0;
    case (pta_pkg::op_e'(in_i.op))
      pta_pkg::OP_MOTION: begin
        job_o.tr = 1'b0; job_o.swap = 1'b0;
      end
      pta_pkg::OP_FORCE: begin
        job_o.tr = 1'b0; job_o.swap = 1'b1;
      end
      pta_pkg::OP_TR_FORCE: begin
        job_o.tr = 1'b1; job_o.swap = 1'b0;
      end
      pta_pkg::OP_TR_MOTION: begin
        job_o.tr = 1'b1; job_o.swap = 1'b1;
      end
      default: begin
        job_o.tr = 1'b0; job_o.swap = 1'b0;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        job_o.q[i][j] = job_o.tr ? rot[j][i] : rot[i][j];
      end
    end
    job_o.p = in_i.offset[3*E-1:0];
    job_o.a = job_o.swap ? in_i.vec_ang[3*E-1:0] : in_i.vec_lin[3*E-1:0];
    job_o.b = job_o.swap ? in_i.vec_lin[3*E-1:0] : in_i.vec_ang[3*E-1:0];
  end

endmodule
`default_nettype wire

// ===== hdl/pta_queue.sv =====
// short job queue between front and back
`default_nettype none
module pta_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pta_pkg::job_t     job_i,
  input  logic              pop_i,
  output pta_pkg::job_t     job_o,
  output pta_pkg::q_stat_t  stat_o
);

  localparam int unsigned D = pta_pkg::QUEUE_DEPTH;

  pta_pkg::job_t                  mem_q [D];
  logic [pta_pkg::QPTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [pta_pkg::QCNT_W-1:0]     cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign stat_o.full  = (cnt_q == pta_pkg::QCNT_W'(D));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign job_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == pta_pkg::QPTR_W'(D - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == pta_pkg::QPTR_W'(D - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= pta_pkg::QCNT_W'(D)) else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not grow on push");

endmodule
`default_nettype wire

// ===== hdl/pta_back.sv =====
// back end: four-stage multiply and round pipeline with output register
`default_nettype none
module pta_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pta_pkg::job_t     job_i,
  input  pta_pkg::q_stat_t  stat_i,
  output logic              pop_o,
  pta_out_if.source         out_o
);

  localparam int unsigned E = pta_pkg::ELEM_WIDTH;

  typedef struct packed {
    logic tr;
    logic swap;
    logic [2:0][2:0][E-1:0] q;
    pta_pkg::vec_t p;
    pta_pkg::vec_t a;
    logic [2:0][2:0][pta_pkg::PROD_W-1:0] qa;
    logic [2:0][2:0][pta_pkg::PROD_W-1:0] qb;
    logic [2:0][pta_pkg::PROD_W-1:0] cx;
    logic [2:0][pta_pkg::PROD_W-1:0] cy;
  } s1_t;

  typedef struct packed {
    logic tr;
    logic swap;
    logic [2:0][2:0][E-1:0] q;
    pta_pkg::vec_t p;
    logic [2:0][pta_pkg::T_W-1:0] t;
    pta_pkg::vec_t ra;
    logic [2:0][pta_pkg::ACC_W-1:0] rbr;
    logic f;
  } s2_t;

  typedef struct packed {
    logic tr;
    logic swap;
    pta_pkg::vec_t ra;
    logic [2:0][pta_pkg::ACC_W-1:0] rbr;
    logic [2:0][2:0][pta_pkg::QT_W-1:0] qt;
    logic [2:0][pta_pkg::PROD_W-1:0] cx;
    logic [2:0][pta_pkg::PROD_W-1:0] cy;
    logic f;
  } s3_t;

  typedef struct packed {
    pta_pkg::vec_t lin;
    pta_pkg::vec_t ang;
    logic f;
  } s4_t;

  s1_t        s1_q, s1_d;
  s2_t        s2_q, s2_d;
  s3_t        s3_q, s3_d;
  s4_t        s4_q, s4_d;
  logic [3:0] vld_q, vld_d;
  logic       en;

  assign en    = !vld_q[3] || out_o.ready;
  assign pop_o = en && !stat_i.empty;
  assign vld_d = en ? {vld_q[2:0], pop_o} : vld_q;

  always_comb begin
    s1_d      = '0;
    s1_d.tr   = job_i.tr;
    s1_d.swap = job_i.swap;
    s1_d.q    = job_i.q;
    s1_d.p    = job_i.p;
    s1_d.a    = job_i.a;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s1_d.qa[i][j] = pta_pkg::prod_t'($signed(job_i.q[i][j]) * $signed(job_i.a[j]));
        s1_d.qb[i][j] = pta_pkg::prod_t'($signed(job_i.q[i][j]) * $signed(job_i.b[j]));
      end
      s1_d.cx[i] = pta_pkg::prod_t'($signed(job_i.p[pta_pkg::nxt(i)])
                                    * $signed(job_i.b[pta_pkg::prv(i)]));
      s1_d.cy[i] = pta_pkg::prod_t'($signed(job_i.p[pta_pkg::prv(i)])
                                    * $signed(job_i.b[pta_pkg::nxt(i)]));
    end
  end

  always_comb begin
    pta_pkg::acc_t sa, sb, c;
    pta_pkg::sat_t st;
    s2_d      = '0;
    s2_d.tr   = s1_q.tr;
    s2_d.swap = s1_q.swap;
    s2_d.q    = s1_q.q;
    s2_d.p    = s1_q.p;
    for (int i = 0; i < 3; i++) begin
      sa = pta_pkg::acc_t'($signed(s1_q.qa[i][0])) + pta_pkg::acc_t'($signed(s1_q.qa[i][1]))
         + pta_pkg::acc_t'($signed(s1_q.qa[i][2]));
      sb = pta_pkg::acc_t'($signed(s1_q.qb[i][0])) + pta_pkg::acc_t'($signed(s1_q.qb[i][1]))
         + pta_pkg::acc_t'($signed(s1_q.qb[i][2]));
      st = pta_pkg::sat_lane(pta_pkg::rnd(sa, pta_pkg::ROT_FRAC_BITS));
      s2_d.ra[i]  = st.v;
      s2_d.f      = s2_d.f | (st.f & s1_q.tr);
      s2_d.rbr[i] = pta_pkg::rnd(sb, pta_pkg::ROT_FRAC_BITS);
      c = pta_pkg::rnd(pta_pkg::acc_t'($signed(s1_q.cx[i]))
                       - pta_pkg::acc_t'($signed(s1_q.cy[i])), pta_pkg::VEC_FRAC_BITS);
      s2_d.t[i] = pta_pkg::diff_t'($signed(s1_q.a[i])) - pta_pkg::diff_t'(c);
    end
  end

  always_comb begin
    s3_d      = '0;
    s3_d.tr   = s2_q.tr;
    s3_d.swap = s2_q.swap;
    s3_d.ra   = s2_q.ra;
    s3_d.rbr  = s2_q.rbr;
    s3_d.f    = s2_q.f;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s3_d.qt[i][j] = pta_pkg::qprod_t'($signed(s2_q.q[i][j]) * $signed(s2_q.t[j]));
      end
      s3_d.cx[i] = pta_pkg::prod_t'($signed(s2_q.p[pta_pkg::nxt(i)])
                                    * $signed(s2_q.ra[pta_pkg::prv(i)]));
      s3_d.cy[i] = pta_pkg::prod_t'($signed(s2_q.p[pta_pkg::prv(i)])
                                    * $signed(s2_q.ra[pta_pkg::nxt(i)]));
    end
  end

  always_comb begin
    pta_pkg::acc_t st_sum, c;
    pta_pkg::sat_t sra, srb;
    pta_pkg::vec_t ra, rb;
    logic          f;
    f   = s3_q.f;
    ra  = '0;
    rb  = '0;
    sra = '0;
    srb = '0;
    for (int i = 0; i < 3; i++) begin
      st_sum = pta_pkg::acc_t'($signed(s3_q.qt[i][0])) + pta_pkg::acc_t'($signed(s3_q.qt[i][1]))
             + pta_pkg::acc_t'($signed(s3_q.qt[i][2]));
      c = pta_pkg::rnd(pta_pkg::acc_t'($signed(s3_q.cx[i]))
                       - pta_pkg::acc_t'($signed(s3_q.cy[i])), pta_pkg::VEC_FRAC_BITS);
      if (s3_q.tr) begin
        ra[i] = s3_q.ra[i];
        srb   = pta_pkg::sat_lane($signed(s3_q.rbr[i]) + c);
        rb[i] = srb.v;
        f     = f | srb.f;
      end else begin
        sra   = pta_pkg::sat_lane(pta_pkg::rnd(st_sum, pta_pkg::ROT_FRAC_BITS));
        srb   = pta_pkg::sat_lane($signed(s3_q.rbr[i]));
        ra[i] = sra.v;
        rb[i] = srb.v;
        f     = f | sra.f | srb.f;
      end
    end
    s4_d.lin = s3_q.swap ? rb : ra;
    s4_d.ang = s3_q.swap ? ra : rb;
    s4_d.f   = f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  assign out_o.valid     = vld_q[3];
  assign out_o.out_lin   = pta_pkg::FIELD_W'(s4_q.lin);
  assign out_o.out_ang   = pta_pkg::FIELD_W'(s4_q.ang);
  assign out_o.saturated = s4_q.f;

endmodule
`default_nettype wire

// ===== hdl/plucker_transform_apply_top.sv =====
// top level of the plucker spatial transform block
// Takes one beat per clock while the queue has room and returns one result beat per input
// beat, in order. Once its job reaches the head of the two-entry queue, a result passes two
// multiply stages, each followed by a rounding and summing stage, the last of which is the
// output register. Sustained rate is one beat per cycle while the output is not stalled; a
// stalled output holds the pipeline and the queue absorbs up to two further input beats.
`default_nettype none
module plucker_transform_apply_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  pta_in_if.sink     in_i,
  pta_out_if.source  out_o
);

  pta_pkg::job_t    push_job, head_job;
  pta_pkg::q_stat_t stat;
  logic             push, pop;

  pta_front u_front (
    .in_i   (in_i),
    .stat_i (stat),
    .push_o (push),
    .job_o  (push_job)
  );

  pta_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (stat)
  );

  pta_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (head_job),
    .stat_i (stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire
